/* hw/rtl/dbscl_pkg.sv */
// dbscl_pkg: constants, types and command/status structs of the dbscan cluster labeler
// no dependencies; used by every other file of the block but dbscl_ram
`default_nettype none

package dbscl_pkg;

	localparam int MAX_POINTS = 64;
	localparam int MAX_DIMS   = 4;
	localparam int COORD_BITS = 16;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int PT_W   = MAX_DIMS * COORD_BITS;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int SUM_W  = SQ_W + $clog2(MAX_DIMS + 1);
	localparam int ACC_W  = COORD_BITS + CNT_W;
	localparam int MAG_W  = ACC_W - 1;

	// fixed field widths
	localparam int EPS_W     = 16;
	localparam int MINP_W    = 7;
	localparam int DIMS_W    = 3;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OIDX_W    = 6;
	localparam int CID_W     = 7;
	localparam int KIND_W    = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EPS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PTS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 2'd2;

	localparam logic [EPS_W-1:0]  EPS_RST  = 16'd256;
	localparam logic [MINP_W-1:0] MINP_RST = 7'd4;
	localparam logic [DIMS_W-1:0] DIMS_RST = 3'd2;

	// point kinds
	localparam logic [KIND_W-1:0] KIND_NOISE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BORDER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CORE   = 2'd2;

	// length of the drain after the last pair issue, before the row is written back
	localparam int PAIR_LAT = 2;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CID_W-1:0]      cid_t;
	typedef logic [MAX_POINTS-1:0] row_t;
	typedef logic [PT_W-1:0]       pt_t;

	typedef struct packed {
		logic in_ready;
		logic pt_we;
		idx_t pt_waddr;
		idx_t idx;
		idx_t jdx;
		logic vis_clear;
		logic pair_issue;
		logic row_wb;
		logic seed;
		logic sweep_issue;
		logic nb_rd_j;
		logic member_wr;
		logic rl_capture;
		logic lab_rd_first;
		logic rl_write;
		logic div_start;
		logic out_load;
		logic last;
		logic ovf;
		cid_t cid;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic seed_ok;
		logic pend_empty;
		logic div_busy;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

/* hw/rtl/dbscl_if.sv */
// dbscl_if: point and result channel interfaces of the dbscan cluster labeler
// depends on dbscl_pkg
`default_nettype none

interface dbscl_pt_if;
	import dbscl_pkg::*;
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] coord_0;
	logic signed [COORD_BITS-1:0] coord_1;
	logic signed [COORD_BITS-1:0] coord_2;
	logic signed [COORD_BITS-1:0] coord_3;
	logic                         last_point;
	modport source (output valid, coord_0, coord_1, coord_2, coord_3, last_point, input ready);
	modport sink (input valid, coord_0, coord_1, coord_2, coord_3, last_point, output ready);
endinterface

interface dbscl_res_if;
	import dbscl_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [OIDX_W-1:0]            point_index;
	logic [CID_W-1:0]             cluster_id;
	logic [KIND_W-1:0]            point_kind;
	logic signed [COORD_BITS-1:0] cluster_one_mean;
	logic                         overflowed;
	logic                         last_result;
	modport source (output valid, point_index, cluster_id, point_kind, cluster_one_mean,
		overflowed, last_result, input ready);
	modport sink (input valid, point_index, cluster_id, point_kind, cluster_one_mean,
		overflowed, last_result, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dbscl_ram.sv */
// dbscl_ram: generic one-write one-read ram with registered read data
// no package dependencies
`default_nettype none

module dbscl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

/* hw/rtl/dbscl_div.sv */
// dbscl_div: restoring divider, one quotient bit per cycle
// depends on dbscl_pkg
`default_nettype none

module dbscl_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [dbscl_pkg::MAG_W-1:0] dividend,
	input  logic [dbscl_pkg::CNT_W-1:0] divisor,
	output logic                    busy,
	output logic                    done,
	output logic [dbscl_pkg::MAG_W-1:0] quot
);
	import dbscl_pkg::*;

	localparam int STEP_W = $clog2(MAG_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_q;
	logic [MAG_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    shifted;
	logic              fits;

	assign shifted = {rem_q[CNT_W-1:0], quo_q[MAG_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
endmodule

`default_nettype wire

/* hw/rtl/dbscl_dp.sv */
// dbscl_dp: datapath of the labeler: point and neighbour rams, distance pipeline,
// cluster bit sets, relabel and mean, result register; depends on dbscl_pkg, dbscl_if,
// dbscl_ram and dbscl_div
`default_nettype none

module dbscl_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	dbscl_pt_if.sink                     points,
	dbscl_res_if.source                  results,
	input  logic [dbscl_pkg::EPS_W-1:0]  eps,
	input  logic [dbscl_pkg::MINP_W-1:0] min_pts,
	input  logic [dbscl_pkg::DIMS_W-1:0] dims_used,
	input  dbscl_pkg::cmd_t              cmd,
	output dbscl_pkg::sts_t              sts
);
	import dbscl_pkg::*;

	pt_t  pt_wdata;
	pt_t  pa_rdata;
	pt_t  pb_rdata;
	row_t nb_rdata;
	idx_t nb_raddr;
	cid_t lab_rdata;
	idx_t lab_raddr;
	idx_t lab_waddr;
	cid_t lab_wdata;
	logic lab_we;

	logic [2*EPS_W-1:0] eps_sq_q;
	logic [DIMS_W-1:0]  dims_eff;

	logic              iss_s1, iss_s2;
	idx_t              j_s1, j_s2;
	logic [COORD_BITS-1:0] mag [MAX_DIMS];
	logic [SQ_W-1:0]   sq_s2 [MAX_DIMS];
	logic [SUM_W-1:0]  dsum;
	logic              in_eps;

	row_t row_q;
	cnt_t nbc_q;
	row_t core_q;
	row_t visited_q;
	row_t pending_q;
	row_t memb_q;
	logic sw_s1;
	idx_t v_s1;
	row_t add;

	row_t cand;
	idx_t first_c;
	idx_t first_q;
	logic has_q;
	logic signed [COORD_BITS-1:0] c0_q;
	cid_t rl_label;

	logic signed [ACC_W-1:0] acc_q;
	cnt_t                    ones_q;
	logic                    acc_neg;
	logic [ACC_W-1:0]        acc_abs;
	logic                    div_busy, div_done;
	logic [MAG_W-1:0]        quot;
	logic [COORD_BITS-1:0]   q16;
	logic [COORD_BITS-1:0]   mean_q;

	logic                    ovalid_q;
	logic [OIDX_W-1:0]       o_idx_q;
	cid_t                    o_cid_q;
	logic [KIND_W-1:0]       o_kind_q;
	logic [COORD_BITS-1:0]   o_mean_q;
	logic                    o_ovf_q;
	logic                    o_last_q;

	assign pt_wdata = {points.coord_3, points.coord_2, points.coord_1, points.coord_0};

	// two copies of the point store give one row point and one column point per cycle
	dbscl_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_a (
		.clk(clk), .we(cmd.pt_we), .waddr(cmd.pt_waddr), .wdata(pt_wdata),
		.raddr(cmd.idx), .rdata(pa_rdata)
	);
	dbscl_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_b (
		.clk(clk), .we(cmd.pt_we), .waddr(cmd.pt_waddr), .wdata(pt_wdata),
		.raddr(cmd.jdx), .rdata(pb_rdata)
	);

	assign nb_raddr = cmd.nb_rd_j ? cmd.jdx : cmd.idx;
	dbscl_ram #(.WIDTH(MAX_POINTS), .DEPTH(MAX_POINTS)) u_nb (
		.clk(clk), .we(cmd.row_wb), .waddr(cmd.idx), .wdata(row_q),
		.raddr(nb_raddr), .rdata(nb_rdata)
	);

	assign lab_raddr = cmd.lab_rd_first ? first_q : cmd.idx;
	assign lab_waddr = cmd.member_wr ? cmd.jdx : cmd.idx;
	assign lab_wdata = cmd.member_wr ? cmd.cid : rl_label;
	assign lab_we    = (cmd.member_wr & memb_q[cmd.jdx]) | cmd.rl_write;
	dbscl_ram #(.WIDTH(CID_W), .DEPTH(MAX_POINTS)) u_lab (
		.clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
		.raddr(lab_raddr), .rdata(lab_rdata)
	);

	always_ff @(posedge clk) begin
		eps_sq_q <= (2*EPS_W)'(eps) * (2*EPS_W)'(eps);
	end

	always_comb begin
		if (dims_used == '0) begin
			dims_eff = DIMS_W'(1);
		end else if (dims_used > DIMS_W'(MAX_DIMS)) begin
			dims_eff = DIMS_W'(MAX_DIMS);
		end else begin
			dims_eff = dims_used;
		end
	end

	// distance pipeline: s1 ram data, s2 squares, then compare into the row
	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			logic signed [COORD_BITS:0] df;
			logic [COORD_BITS:0]        ad;
			df = (COORD_BITS+1)'(signed'(pa_rdata[d*COORD_BITS +: COORD_BITS]))
				- (COORD_BITS+1)'(signed'(pb_rdata[d*COORD_BITS +: COORD_BITS]));
			ad = df[COORD_BITS] ? -df : df;
			mag[d] = ad[COORD_BITS-1:0];
		end
	end

	always_comb begin
		dsum = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			dsum = dsum + SUM_W'(sq_s2[d]);
		end
	end
	assign in_eps = dsum <= SUM_W'(eps_sq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= 1'b0;
			iss_s2 <= 1'b0;
			sw_s1  <= 1'b0;
		end else begin
			iss_s1 <= cmd.pair_issue;
			iss_s2 <= iss_s1;
			sw_s1  <= cmd.sweep_issue;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= cmd.jdx;
		j_s2 <= j_s1;
		v_s1 <= cmd.jdx;
		for (int d = 0; d < MAX_DIMS; d++) begin
			sq_s2[d] <= (d < int'(dims_eff)) ? SQ_W'(mag[d]) * SQ_W'(mag[d]) : '0;
		end
	end

	assign add = nb_rdata & core_q & ~visited_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			nbc_q     <= '0;
			core_q    <= '0;
			visited_q <= '0;
			pending_q <= '0;
			memb_q    <= '0;
		end else begin
			if (cmd.vis_clear || cmd.row_wb) begin
				row_q <= '0;
				nbc_q <= '0;
			end else if (iss_s2 && in_eps) begin
				row_q[j_s2] <= 1'b1;
				nbc_q       <= nbc_q + 1'b1;
			end
			if (cmd.vis_clear) begin
				core_q <= '0;
			end else if (cmd.row_wb) begin
				core_q[cmd.idx] <= nbc_q >= min_pts;
			end
			if (cmd.vis_clear) begin
				visited_q <= '0;
				pending_q <= '0;
				memb_q    <= '0;
			end else if (cmd.seed) begin
				visited_q[cmd.idx] <= 1'b1;
				pending_q <= row_t'(1) << cmd.idx;
				memb_q    <= row_t'(1) << cmd.idx;
			end else if (sw_s1 && pending_q[v_s1]) begin
				visited_q <= visited_q | add;
				memb_q    <= memb_q | add;
				pending_q <= (pending_q | add) & ~(row_t'(1) << v_s1);
			end
		end
	end

	// first core neighbour of the row being relabeled
	assign cand = nb_rdata & core_q;
	always_comb begin
		first_c = '0;
		for (int k = MAX_POINTS - 1; k >= 0; k--) begin
			if (cand[k]) begin
				first_c = idx_t'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rl_capture) begin
			first_q <= first_c;
			has_q   <= |cand;
			c0_q    <= signed'(pa_rdata[COORD_BITS-1:0]);
		end
	end

	assign rl_label = has_q ? lab_rdata : '0;

	always_ff @(posedge clk) begin
		if (cmd.vis_clear) begin
			acc_q  <= '0;
			ones_q <= '0;
		end else if (cmd.rl_write && rl_label == CID_W'(1)) begin
			acc_q  <= acc_q + ACC_W'(c0_q);
			ones_q <= ones_q + 1'b1;
		end
	end

	assign acc_neg = acc_q[ACC_W-1];
	assign acc_abs = acc_neg ? -acc_q : acc_q;

	dbscl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(acc_abs[MAG_W-1:0]), .divisor(ones_q),
		.busy(div_busy), .done(div_done), .quot(quot)
	);

	assign q16 = quot[COORD_BITS-1:0];
	always_ff @(posedge clk) begin
		if (div_done) begin
			if (ones_q == '0) begin
				mean_q <= '0;
			end else begin
				mean_q <= acc_neg ? -q16 : q16;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_idx_q  <= OIDX_W'(cmd.idx);
			o_cid_q  <= lab_rdata;
			o_kind_q <= core_q[cmd.idx] ? KIND_CORE :
				(lab_rdata != '0) ? KIND_BORDER : KIND_NOISE;
			o_mean_q <= mean_q;
			o_ovf_q  <= cmd.ovf;
			o_last_q <= cmd.last;
		end
	end

	assign points.ready             = cmd.in_ready;
	assign results.valid            = ovalid_q;
	assign results.point_index      = o_idx_q;
	assign results.cluster_id       = o_cid_q;
	assign results.point_kind       = o_kind_q;
	assign results.cluster_one_mean = signed'(o_mean_q);
	assign results.overflowed       = o_ovf_q;
	assign results.last_result      = o_last_q;

	assign sts.in_valid   = points.valid;
	assign sts.in_last    = points.last_point;
	assign sts.seed_ok    = core_q[cmd.idx] & ~visited_q[cmd.idx];
	assign sts.pend_empty = pending_q == '0;
	assign sts.div_busy   = div_busy;
	assign sts.out_busy   = ovalid_q;
endmodule

`default_nettype wire

/* hw/rtl/dbscl_ctrl.sv */
// dbscl_ctrl: sequencer of the labeler: load, pair pass, cluster growth, relabel, mean, emit
// depends on dbscl_pkg
`default_nettype none

module dbscl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  dbscl_pkg::sts_t sts,
	output dbscl_pkg::cmd_t cmd
);
	import dbscl_pkg::*;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_LOAD    = 5'd0;
	localparam logic [ST_W-1:0] ST_P_ISS   = 5'd1;
	localparam logic [ST_W-1:0] ST_P_DRN   = 5'd2;
	localparam logic [ST_W-1:0] ST_P_WB    = 5'd3;
	localparam logic [ST_W-1:0] ST_SEED    = 5'd4;
	localparam logic [ST_W-1:0] ST_SWP     = 5'd5;
	localparam logic [ST_W-1:0] ST_SWP_END = 5'd6;
	localparam logic [ST_W-1:0] ST_SWP_CHK = 5'd7;
	localparam logic [ST_W-1:0] ST_LWR     = 5'd8;
	localparam logic [ST_W-1:0] ST_RL_A    = 5'd9;
	localparam logic [ST_W-1:0] ST_RL_B    = 5'd10;
	localparam logic [ST_W-1:0] ST_RL_C    = 5'd11;
	localparam logic [ST_W-1:0] ST_RL_D    = 5'd12;
	localparam logic [ST_W-1:0] ST_DIV_GO  = 5'd13;
	localparam logic [ST_W-1:0] ST_DIV_W   = 5'd14;
	localparam logic [ST_W-1:0] ST_EM_A    = 5'd15;
	localparam logic [ST_W-1:0] ST_EM_B    = 5'd16;

	localparam int DRN_W = $clog2(PAIR_LAT + 1);

	logic [ST_W-1:0]  state_q, state_d;
	idx_t             i_q, i_d, j_q, j_d;
	logic [DRN_W-1:0] drn_q, drn_d;
	cid_t             cid_q, cid_d;
	cnt_t             cnt_q, cnt_d;
	logic             ovf_q, ovf_d;
	cnt_t             nm1_c;
	idx_t             nm1;

	assign nm1_c = cnt_q - CNT_W'(1);
	assign nm1   = nm1_c[IDX_W-1:0];

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		drn_d   = drn_q;
		cid_d   = cid_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		cmd          = '0;
		cmd.idx      = i_q;
		cmd.jdx      = j_q;
		cmd.cid      = cid_q;
		cmd.ovf      = ovf_q;
		cmd.pt_waddr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			ST_LOAD: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					if (cnt_q < CNT_W'(MAX_POINTS)) begin
						cmd.pt_we = 1'b1;
						cnt_d     = cnt_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (sts.in_last) begin
						cmd.vis_clear = 1'b1;
						i_d     = '0;
						j_d     = '0;
						cid_d   = '0;
						state_d = ST_P_ISS;
					end
				end
			end
			ST_P_ISS: begin
				cmd.pair_issue = 1'b1;
				if (j_q == nm1) begin
					drn_d   = '0;
					state_d = ST_P_DRN;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_P_DRN: begin
				drn_d = drn_q + 1'b1;
				if (drn_q == DRN_W'(PAIR_LAT)) begin
					state_d = ST_P_WB;
				end
			end
			ST_P_WB: begin
				cmd.row_wb = 1'b1;
				j_d = '0;
				if (i_q == nm1) begin
					i_d     = '0;
					state_d = ST_SEED;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_P_ISS;
				end
			end
			ST_SEED: begin
				if (sts.seed_ok) begin
					cmd.seed = 1'b1;
					cid_d    = cid_q + 1'b1;
					j_d      = '0;
					state_d  = ST_SWP;
				end else if (i_q == nm1) begin
					i_d     = '0;
					state_d = ST_RL_A;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			ST_SWP: begin
				cmd.sweep_issue = 1'b1;
				cmd.nb_rd_j     = 1'b1;
				if (j_q == nm1) begin
					state_d = ST_SWP_END;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_SWP_END: begin
				state_d = ST_SWP_CHK;
			end
			ST_SWP_CHK: begin
				j_d     = '0;
				state_d = sts.pend_empty ? ST_LWR : ST_SWP;
			end
			ST_LWR: begin
				cmd.member_wr = 1'b1;
				if (j_q == nm1) begin
					state_d = ST_SEED;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_RL_A: begin
				state_d = ST_RL_B;
			end
			ST_RL_B: begin
				cmd.rl_capture = 1'b1;
				state_d = ST_RL_C;
			end
			ST_RL_C: begin
				cmd.lab_rd_first = 1'b1;
				state_d = ST_RL_D;
			end
			ST_RL_D: begin
				cmd.rl_write = 1'b1;
				if (i_q == nm1) begin
					state_d = ST_DIV_GO;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ST_RL_A;
				end
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV_W;
			end
			ST_DIV_W: begin
				if (!sts.div_busy) begin
					i_d     = '0;
					state_d = ST_EM_A;
				end
			end
			ST_EM_A: begin
				state_d = ST_EM_B;
			end
			ST_EM_B: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.last     = i_q == nm1;
					if (i_q == nm1) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = ST_LOAD;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_EM_A;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			i_q     <= '0;
			j_q     <= '0;
			drn_q   <= '0;
			cid_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			drn_q   <= drn_d;
			cid_q   <= cid_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond capacity");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten");
	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pair_issue || cmd.sweep_issue) |-> (CNT_W'(j_q) < cnt_q))
		else $error("column index past stored points");
	a_seed_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed |=> (state_q == ST_SWP && j_q == '0))
		else $error("seed not followed by sweep");
`endif
endmodule

`default_nettype wire

/* hw/rtl/dbscan_cluster_labeler.sv */
// dbscan_cluster_labeler: top level, configuration registers, controller and datapath
// depends on dbscl_pkg, dbscl_if, dbscl_ctrl, dbscl_dp
//
// usage
//  points channel: one item per point, four signed q8.8 coordinates and last_point;
//   taken one per cycle while loading; points past capacity are dropped and flagged
//  the item with last_point set closes the set and starts clustering; points is not
//   ready again until every result of the set has been handed to the result register
//  results channel: one item per stored point in load order, carrying cluster number,
//   kind, the cluster one mean, the overflow flag and last_result on the final one
//  after the last point come the pair pass (one pair per cycle through the distance
//   pipeline), per cluster one or more neighbour-ram sweeps and a label write, a relabel
//   pass, the mean divider, then the results one by one
//  a stalled receiver holds the result register; the sequencer waits on it and resumes
//   when the item is taken, with no loss or repeat
//  configuration writes (eps, min_pts, dims_used) are registered and are meant for
//   idle periods; reset restores eps 1.0, min_pts 4, dims_used 2 and an empty set
`default_nettype none

module dbscan_cluster_labeler (
	input  logic                            clk,
	input  logic                            arst_n,
	dbscl_pt_if.sink                        points,
	dbscl_res_if.source                     results,
	input  logic                            cfg_we,
	input  logic [dbscl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dbscl_pkg::CFG_W-1:0]     cfg_wdata
);
	import dbscl_pkg::*;

	logic [EPS_W-1:0]  eps_q;
	logic [MINP_W-1:0] min_pts_q;
	logic [DIMS_W-1:0] dims_q;
	cmd_t              cmd;
	sts_t              sts;

	// configuration registers, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q     <= EPS_RST;
			min_pts_q <= MINP_RST;
			dims_q    <= DIMS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_EPS:     eps_q     <= cfg_wdata[EPS_W-1:0];
				REG_MIN_PTS: min_pts_q <= cfg_wdata[MINP_W-1:0];
				REG_DIMS:    dims_q    <= cfg_wdata[DIMS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: owns point count, overflow flag and loop counters
	dbscl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	// datapath: rams, distance pipeline, cluster sets, divider, result register
	dbscl_dp u_dp (
		.clk(clk), .arst_n(arst_n), .points(points), .results(results),
		.eps(eps_q), .min_pts(min_pts_q), .dims_used(dims_q),
		.cmd(cmd), .sts(sts)
	);
endmodule

`default_nettype wire
